// ===== sv/i2cseq_pkg.sv =====
package i2cseq_pkg;

   localparam int MAX_TRANSFER = 255;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_STATUS = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      START_NONE  = 2'd0,
      START_SET   = 2'd1,
      START_CLEAR = 2'd2
   } start_action_type;

   typedef enum logic [1:0] {
      ACK_NONE   = 2'd0,
      ACK_ASSERT = 2'd1,
      ACK_CLEAR  = 2'd2
   } ack_action_type;

   localparam logic [7:0] ST_START    = 8'h08;
   localparam logic [7:0] ST_RESTART  = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK = 8'h18;
   localparam logic [7:0] ST_DATA_ACK = 8'h28;
   localparam logic [7:0] ST_SLAR_ACK = 8'h40;
   localparam logic [7:0] ST_RX_ACK   = 8'h50;
   localparam logic [7:0] ST_RX_NACK  = 8'h58;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] slave_addr;
      logic [7:0] reg_index;
      logic [7:0] byte_count;
      logic [7:0] status_code;
      logic [7:0] rx_byte;
      logic [7:0] tx_byte;
   } req_type;

   typedef struct packed {
      logic       data_load_valid;
      logic [7:0] data_load;
      logic [1:0] start_action;
      logic       stop_set;
      logic [1:0] ack_action;
      logic       irq_clear;
      logic       tx_taken;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       done_res;
      logic       bus_error;
   } rsp_type;

endpackage

// ===== sv/i2cseq_in_reg.sv =====
module i2cseq_in_reg
   import i2cseq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   input  logic    pass_ready,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff, valid_in;
   req_type item_ff;

   assign req_stall  = valid_ff && !pass_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (!valid_ff || pass_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== sv/i2cseq_core.sv =====
module i2cseq_core
   import i2cseq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   output rsp_type rsp
);

   logic [7:0] address_byte_ff, address_byte_in;
   logic [7:0] register_index_ff, register_index_in;
   logic [7:0] remaining_count_ff, remaining_count_in;
   logic [7:0] count_dec;
   logic [7:0] count_start;

   assign count_dec = (remaining_count_ff != 8'd0) ? remaining_count_ff - 8'd1 : 8'd0;

   always_comb begin
      count_start = item.byte_count;
      if (32'(item.byte_count) > MAX_TRANSFER) begin
         count_start = 8'(MAX_TRANSFER);
      end
   end

   always_comb begin
      address_byte_in    = address_byte_ff;
      register_index_in  = register_index_ff;
      remaining_count_in = remaining_count_ff;
      rsp                = '0;
      case (item.cmd)
         CMD_WRITE, CMD_READ: begin
            address_byte_in    = {item.slave_addr[7:1], (item.cmd == CMD_READ)};
            register_index_in  = item.reg_index;
            remaining_count_in = count_start;
            rsp.start_action   = START_SET;
         end
         CMD_STATUS: begin
            rsp.irq_clear = 1'b1;
            case (item.status_code)
               ST_START: begin
                  rsp.data_load_valid = 1'b1;
                  rsp.data_load       = {address_byte_ff[7:1], 1'b0};
               end
               ST_RESTART: begin
                  rsp.data_load_valid = 1'b1;
                  rsp.data_load       = address_byte_ff;
               end
               ST_SLAW_ACK: begin
                  rsp.start_action    = START_CLEAR;
                  rsp.data_load_valid = 1'b1;
                  rsp.data_load       = register_index_ff;
               end
               ST_DATA_ACK: begin
                  if (address_byte_ff[0]) begin
                     rsp.start_action = START_SET;
                  end else if (remaining_count_ff != 8'd0) begin
                     rsp.data_load_valid = 1'b1;
                     rsp.data_load       = item.tx_byte;
                     rsp.tx_taken        = 1'b1;
                     remaining_count_in  = count_dec;
                  end else begin
                     rsp.stop_set = 1'b1;
                     rsp.done_res = 1'b1;
                  end
               end
               ST_SLAR_ACK: begin
                  rsp.start_action = START_CLEAR;
                  rsp.ack_action   = (remaining_count_ff >= 8'd2) ? ACK_ASSERT : ACK_CLEAR;
               end
               ST_RX_ACK: begin
                  rsp.rx_valid       = 1'b1;
                  rsp.rx_data        = item.rx_byte;
                  remaining_count_in = count_dec;
                  rsp.ack_action     = (count_dec >= 8'd2) ? ACK_ASSERT : ACK_CLEAR;
               end
               ST_RX_NACK: begin
                  rsp.rx_valid       = 1'b1;
                  rsp.rx_data        = item.rx_byte;
                  remaining_count_in = count_dec;
                  rsp.stop_set       = 1'b1;
                  rsp.ack_action     = ACK_ASSERT;
                  rsp.done_res       = 1'b1;
               end
               default: begin
                  rsp.stop_set  = 1'b1;
                  rsp.bus_error = 1'b1;
               end
            endcase
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_byte_ff    <= 8'd0;
         register_index_ff  <= 8'd0;
         remaining_count_ff <= 8'd0;
      end else if (fire) begin
         address_byte_ff    <= address_byte_in;
         register_index_ff  <= register_index_in;
         remaining_count_ff <= remaining_count_in;
      end
   end

endmodule

// ===== sv/i2cseq_out_reg.sv =====
module i2cseq_out_reg
   import i2cseq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load_valid,
   input  rsp_type rsp_in,
   output logic    pass_ready,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_out
);

   logic    valid_ff, valid_in;
   rsp_type rsp_ff;

   assign pass_ready = !valid_ff || !rsp_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_out    = rsp_ff;

   always_comb begin
      valid_in = valid_ff;
      if (pass_ready) begin
         valid_in = load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && pass_ready) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== sv/i2c_master_register_transfer_sequencer.sv =====
// I2C master register transfer sequencer. Takes one command or controller status
// event per clock unless req_stall is high, and returns exactly one set of controller
// actions for each, in order, through the input register and then through the status
// decoder into the result register. The slave address, register index and
// remaining byte count are held between transfers; a start command loads them,
// status events walk the write or read sequence and count bytes down to zero.
module i2c_master_register_transfer_sequencer
   import i2cseq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_slave_addr,
   input  logic [7:0] req_reg_index,
   input  logic [7:0] req_byte_count,
   input  logic [7:0] req_status_code,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_tx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_data_load_valid,
   output logic [7:0] rsp_data_load,
   output logic [1:0] rsp_start_action,
   output logic       rsp_stop_set,
   output logic [1:0] rsp_ack_action,
   output logic       rsp_irq_clear,
   output logic       rsp_tx_taken,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_data,
   output logic       rsp_done_res,
   output logic       rsp_bus_error
);

   req_type req_item, item;
   rsp_type rsp_next, rsp_out;
   logic    item_valid, pass_ready;

   assign req_item = '{cmd: req_cmd, slave_addr: req_slave_addr, reg_index: req_reg_index,
                       byte_count: req_byte_count, status_code: req_status_code,
                       rx_byte: req_rx_byte, tx_byte: req_tx_byte};

   i2cseq_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .pass_ready (pass_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cseq_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (item_valid && pass_ready),
      .item  (item),
      .rsp   (rsp_next)
   );

   i2cseq_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (item_valid),
      .rsp_in     (rsp_next),
      .pass_ready (pass_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_out    (rsp_out)
   );

   assign rsp_data_load_valid = rsp_out.data_load_valid;
   assign rsp_data_load       = rsp_out.data_load;
   assign rsp_start_action    = rsp_out.start_action;
   assign rsp_stop_set        = rsp_out.stop_set;
   assign rsp_ack_action      = rsp_out.ack_action;
   assign rsp_irq_clear       = rsp_out.irq_clear;
   assign rsp_tx_taken        = rsp_out.tx_taken;
   assign rsp_rx_valid        = rsp_out.rx_valid;
   assign rsp_rx_data         = rsp_out.rx_data;
   assign rsp_done_res        = rsp_out.done_res;
   assign rsp_bus_error       = rsp_out.bus_error;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result register can drain");

   a_error_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_bus_error || rsp_done_res) |-> rsp_stop_set && rsp_irq_clear)
      else $error("done or bus error without stop");

   a_tx_loads: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_taken |-> rsp_data_load_valid && !rsp_rx_valid)
      else $error("write byte taken without data load");

   a_rx_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_valid |-> rsp_irq_clear && !rsp_data_load_valid)
      else $error("received byte outside a status event");

endmodule

// ===== dv/i2c_action_check_pkg.sv =====
`timescale 1ns / 100ps
package i2c_action_check_pkg;
   import i2cseq_pkg::*;

   localparam logic [1:0] CMD_RESERVED = 2'd3;

   class i2c_action_tracker;
      logic [7:0] addr_byte;
      logic [7:0] reg_idx;
      logic [7:0] bytes_left;
      rsp_type    pending_actions[$];
      int         mismatches;
      int         writes_started;
      int         reads_started;
      int         reserved_cmds;
      int         status_events;
      int         completions;
      int         bus_errors;
      int         bytes_sent;
      int         bytes_received;
      int         results_checked;

      function new();
         addr_byte       = '0;
         reg_idx         = '0;
         bytes_left      = '0;
         mismatches      = 0;
         writes_started  = 0;
         reads_started   = 0;
         reserved_cmds   = 0;
         status_events   = 0;
         completions     = 0;
         bus_errors      = 0;
         bytes_sent      = 0;
         bytes_received  = 0;
         results_checked = 0;
      endfunction

      function void count_down();
         if (bytes_left != 0)
            bytes_left = bytes_left - 8'd1;
      endfunction

      function logic [1:0] ack_for_left();
         return (bytes_left >= 8'd2) ? ACK_ASSERT : ACK_CLEAR;
      endfunction

      function rsp_type predict_actions(req_type r);
         rsp_type a;
         a = '0;
         case (r.cmd)
            CMD_WRITE, CMD_READ: begin
               addr_byte  = {r.slave_addr[7:1], r.cmd == CMD_READ};
               reg_idx    = r.reg_index;
               bytes_left = (int'(r.byte_count) > MAX_TRANSFER) ? 8'(MAX_TRANSFER)
                                                                : r.byte_count;
               a.start_action = START_SET;
            end
            CMD_STATUS: begin
               a.irq_clear = 1'b1;
               case (r.status_code)
                  ST_START: begin
                     a.data_load_valid = 1'b1;
                     a.data_load       = {addr_byte[7:1], 1'b0};
                  end
                  ST_RESTART: begin
                     a.data_load_valid = 1'b1;
                     a.data_load       = addr_byte;
                  end
                  ST_SLAW_ACK: begin
                     a.start_action    = START_CLEAR;
                     a.data_load_valid = 1'b1;
                     a.data_load       = reg_idx;
                  end
                  ST_DATA_ACK: begin
                     if (addr_byte[0]) begin
                        a.start_action = START_SET;
                     end else if (bytes_left != 0) begin
                        a.data_load_valid = 1'b1;
                        a.data_load       = r.tx_byte;
                        a.tx_taken        = 1'b1;
                        count_down();
                     end else begin
                        a.stop_set = 1'b1;
                        a.done_res = 1'b1;
                     end
                  end
                  ST_SLAR_ACK: begin
                     a.start_action = START_CLEAR;
                     a.ack_action   = ack_for_left();
                  end
                  ST_RX_ACK: begin
                     a.rx_valid = 1'b1;
                     a.rx_data  = r.rx_byte;
                     count_down();
                     a.ack_action = ack_for_left();
                  end
                  ST_RX_NACK: begin
                     a.rx_valid = 1'b1;
                     a.rx_data  = r.rx_byte;
                     count_down();
                     a.stop_set   = 1'b1;
                     a.ack_action = ACK_ASSERT;
                     a.done_res   = 1'b1;
                  end
                  default: begin
                     a.stop_set  = 1'b1;
                     a.bus_error = 1'b1;
                  end
               endcase
            end
            default: begin
            end
         endcase
         return a;
      endfunction

      function void note_request(req_type r);
         rsp_type a;
         a = predict_actions(r);
         if (r.cmd == CMD_WRITE)
            writes_started++;
         else if (r.cmd == CMD_READ)
            reads_started++;
         else if (r.cmd == CMD_STATUS)
            status_events++;
         else
            reserved_cmds++;
         completions    += a.done_res;
         bus_errors     += a.bus_error;
         bytes_sent     += a.tx_taken;
         bytes_received += a.rx_valid;
         pending_actions.push_back(a);
      endfunction

      function int pending();
         return pending_actions.size();
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_actions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result %h arrived with nothing outstanding", $time, got);
            return;
         end
         want = pending_actions.pop_front();
         results_checked++;
         compare_field("data_load_valid", want.data_load_valid, got.data_load_valid);
         compare_field("data_load", want.data_load, got.data_load);
         compare_field("start_action", want.start_action, got.start_action);
         compare_field("stop_set", want.stop_set, got.stop_set);
         compare_field("ack_action", want.ack_action, got.ack_action);
         compare_field("irq_clear", want.irq_clear, got.irq_clear);
         compare_field("tx_taken", want.tx_taken, got.tx_taken);
         compare_field("rx_valid", want.rx_valid, got.rx_valid);
         compare_field("rx_data", want.rx_data, got.rx_data);
         compare_field("done_res", want.done_res, got.done_res);
         compare_field("bus_error", want.bus_error, got.bus_error);
      endfunction

      function void finish_check();
         if (pending_actions.size() != 0) begin
            mismatches += pending_actions.size();
            $display("%0d expected results never arrived", pending_actions.size());
         end
      endfunction
   endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
   import i2cseq_pkg::*;
   import i2c_action_check_pkg::*;

   localparam int TARGET_ITEMS = 1900;
   localparam int LONG_HOLD    = 64;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_drive;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_data_load_valid;
   logic [7:0] rsp_data_load;
   logic [1:0] rsp_start_action;
   logic       rsp_stop_set;
   logic [1:0] rsp_ack_action;
   logic       rsp_irq_clear;
   logic       rsp_tx_taken;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_data;
   logic       rsp_done_res;
   logic       rsp_bus_error;
   rsp_type    rsp_seen;
   logic       long_hold_req;
   logic       no_gaps;
   int         items_sent;
   i2c_action_tracker tracker;

   i2c_master_register_transfer_sequencer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_drive.cmd),
      .req_slave_addr     (req_drive.slave_addr),
      .req_reg_index      (req_drive.reg_index),
      .req_byte_count     (req_drive.byte_count),
      .req_status_code    (req_drive.status_code),
      .req_rx_byte        (req_drive.rx_byte),
      .req_tx_byte        (req_drive.tx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_load_valid(rsp_data_load_valid),
      .rsp_data_load      (rsp_data_load),
      .rsp_start_action   (rsp_start_action),
      .rsp_stop_set       (rsp_stop_set),
      .rsp_ack_action     (rsp_ack_action),
      .rsp_irq_clear      (rsp_irq_clear),
      .rsp_tx_taken       (rsp_tx_taken),
      .rsp_rx_valid       (rsp_rx_valid),
      .rsp_rx_data        (rsp_rx_data),
      .rsp_done_res       (rsp_done_res),
      .rsp_bus_error      (rsp_bus_error)
   );

   assign rsp_seen = {rsp_data_load_valid, rsp_data_load, rsp_start_action, rsp_stop_set,
                      rsp_ack_action, rsp_irq_clear, rsp_tx_taken, rsp_rx_valid,
                      rsp_rx_data, rsp_done_res, rsp_bus_error};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   function automatic logic [7:0] rand8();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if ((items_sent / 100) % 5 == 4)
         return 0;
      if (roll == 0)
         return $urandom_range(10, 30);
      if (roll < 8)
         return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic int pick_count();
      if ($urandom_range(0, 39) == 0)
         return $urandom_range(16, 255);
      return $urandom_range(0, 6);
   endfunction

   // corrupt roughly one step in twelve to break the sequence
   function automatic logic [7:0] noisy(logic [7:0] code);
      if ($urandom_range(0, 11) == 0)
         return rand8();
      return code;
   endfunction

   function automatic req_type rand_req(logic [1:0] cmd);
      req_type r;
      r.cmd         = cmd;
      r.slave_addr  = rand8();
      r.reg_index   = rand8();
      r.byte_count  = rand8();
      r.status_code = rand8();
      r.rx_byte     = rand8();
      r.tx_byte     = rand8();
      return r;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_drive <= item;
      do @(posedge clock); while (req_stall);
      tracker.note_request(item);
      if (item.cmd != CMD_RESERVED)
         items_sent++;
   endtask

   task automatic send_start(input logic [1:0] cmd, input logic [7:0] sa,
                             input logic [7:0] ri, input logic [7:0] bc);
      req_type r;
      r            = rand_req(cmd);
      r.slave_addr = sa;
      r.reg_index  = ri;
      r.byte_count = bc;
      send_item(r);
   endtask

   task automatic send_event(input logic [7:0] code, input logic [7:0] rx,
                             input logic [7:0] tx);
      req_type r;
      r             = rand_req(CMD_STATUS);
      r.status_code = code;
      r.rx_byte     = rx;
      r.tx_byte     = tx;
      send_item(r);
   endtask

   task automatic write_sequence();
      int n;
      n = pick_count();
      send_start(CMD_WRITE, rand8(), rand8(), 8'(n));
      send_event(noisy(ST_START), rand8(), rand8());
      send_event(noisy(ST_SLAW_ACK), rand8(), rand8());
      repeat (n + 1) send_event(noisy(ST_DATA_ACK), rand8(), rand8());
   endtask

   task automatic read_sequence();
      int n;
      n = pick_count();
      send_start(CMD_READ, rand8(), rand8(), 8'(n));
      send_event(noisy(ST_START), rand8(), rand8());
      send_event(noisy(ST_SLAW_ACK), rand8(), rand8());
      send_event(noisy(ST_DATA_ACK), rand8(), rand8());
      send_event(noisy(ST_RESTART), rand8(), rand8());
      send_event(noisy(ST_SLAR_ACK), rand8(), rand8());
      repeat ((n > 0) ? n - 1 : 0) send_event(noisy(ST_RX_ACK), rand8(), rand8());
      send_event(noisy(ST_RX_NACK), rand8(), rand8());
   endtask

   task automatic noise_burst();
      logic [7:0] known_codes[7];
      int roll;
      known_codes = '{ST_START, ST_RESTART, ST_SLAW_ACK, ST_DATA_ACK,
                      ST_SLAR_ACK, ST_RX_ACK, ST_RX_NACK};
      repeat ($urandom_range(1, 6)) begin
         roll = $urandom_range(0, 11);
         if (roll == 0)
            send_item(rand_req(CMD_RESERVED));
         else if (roll < 4)
            send_start(roll[0] ? CMD_READ : CMD_WRITE, rand8(), rand8(), rand8());
         else if (roll < 8)
            send_event(known_codes[$urandom_range(0, 6)], rand8(), rand8());
         else
            send_event(rand8(), rand8(), rand8());
      end
   endtask

   initial begin : receiver
      int   run_left;
      logic stall_now;
      rsp_stall = 1'b0;
      run_left  = 0;
      stall_now = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
            long_hold_req = 1'b0;
            run_left      = 0;
         end else if (run_left == 0) begin
            stall_now = ($urandom_range(0, 2) == 0);
            if (stall_now)
               run_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
            else
               run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 8);
            rsp_stall <= stall_now;
         end else begin
            run_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(rsp_seen);
   end

   initial begin : stimulus
      int   pick;
      logic hold_done;
      logic drain_done;
      req_type odd;
      tracker       = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_drive     = '0;
      long_hold_req = 1'b0;
      no_gaps       = 1'b0;
      items_sent    = 0;
      hold_done     = 1'b0;
      drain_done    = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // write of two bytes, then the empty-count stop
      send_start(CMD_WRITE, 8'hFF, 8'h00, 8'd2);
      send_event(ST_START, 8'hFF, 8'h00);
      send_event(ST_SLAW_ACK, 8'h00, 8'hFF);
      send_event(ST_DATA_ACK, 8'h00, 8'hFF);
      send_event(ST_DATA_ACK, 8'hFF, 8'h00);
      send_event(ST_DATA_ACK, 8'h5A, 8'hA5);
      // read of three bytes through the repeated start
      send_start(CMD_READ, 8'h00, 8'hFF, 8'd3);
      send_event(ST_START, 8'h00, 8'h00);
      send_event(ST_SLAW_ACK, 8'h00, 8'h00);
      send_event(ST_DATA_ACK, 8'h00, 8'h00);
      send_event(ST_RESTART, 8'h00, 8'h00);
      send_event(ST_SLAR_ACK, 8'h00, 8'h00);
      send_event(ST_RX_ACK, 8'hFF, 8'h00);
      send_event(ST_RX_ACK, 8'h00, 8'hFF);
      send_event(ST_RX_NACK, 8'hA5, 8'h00);
      // count already at zero: hold at zero
      send_event(ST_RX_ACK, 8'h3C, 8'h00);
      send_event(ST_RX_NACK, 8'hC3, 8'h00);
      // unknown status codes
      send_event(8'h00, 8'h00, 8'h00);
      send_event(8'hFF, 8'hFF, 8'hFF);
      // reserved command is ignored
      odd = '1;
      send_item(odd);
      send_start(CMD_READ, 8'hA4, 8'h5B, 8'd0);
      send_event(ST_SLAR_ACK, 8'h00, 8'h00);
      send_start(CMD_WRITE, 8'h5B, 8'hA4, 8'hFF);
      send_event(ST_DATA_ACK, 8'h00, 8'hFF);

      while (items_sent < TARGET_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 4)
            write_sequence();
         else if (pick < 8)
            read_sequence();
         else
            noise_burst();
         if (!hold_done && items_sent > 600) begin
            hold_done     = 1'b1;
            long_hold_req = 1'b1;
            no_gaps       = 1'b1;
            repeat (3) read_sequence();
            no_gaps       = 1'b0;
         end
         if (!drain_done && items_sent > 1200) begin
            drain_done = 1'b1;
            @(negedge clock);
            req_valid <= 1'b0;
            while (tracker.pending() != 0) @(posedge clock);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      tracker.finish_check();
      $display("tb_top: %0d writes, %0d reads, %0d status events, %0d ignored commands",
               tracker.writes_started, tracker.reads_started, tracker.status_events,
               tracker.reserved_cmds);
      $display("tb_top: %0d bytes sent, %0d received, %0d completions, %0d bus errors",
               tracker.bytes_sent, tracker.bytes_received, tracker.completions,
               tracker.bus_errors);
      if (tracker.mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
sv/i2cseq_pkg.sv
sv/i2cseq_in_reg.sv
sv/i2cseq_core.sv
sv/i2cseq_out_reg.sv
sv/i2c_master_register_transfer_sequencer.sv
dv/i2c_action_check_pkg.sv
dv/tb_top.sv
